@@ rtl/smbus_pec_read_word_checker_macros.svh @@
// Assertion macros for the SMBus PEC read-word checker.
// Used by smbus_pec_read_word_checker.sv; no other dependencies.
`ifndef SMBUS_PEC_READ_WORD_CHECKER_MACROS_SVH
`define SMBUS_PEC_READ_WORD_CHECKER_MACROS_SVH

// same-cycle implication
`define SPC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define SPC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/smbpec_pkg.sv @@
// Package for the SMBus PEC read-word checker: constants, status codes, CRC-8 step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smbpec_pkg;

    localparam int unsigned ADDR_W     = 7;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned TEMP_W     = 17;
    localparam int unsigned S_TDATA_W  = 32;
    localparam int unsigned M_TDATA_W  = 40;
    localparam int unsigned M_TUSER_W  = 3;
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned PDATA_W    = 32;

    localparam logic [BYTE_W-1:0]   PEC_POLY     = 8'h07;
    localparam logic [BYTE_W-1:0]   PEC_INIT     = 8'h00;
    localparam logic [ADDR_W-1:0]   ADDR_RESET   = 7'd90;
    localparam logic [TEMP_W-1:0]   ZERO_C_CENTI = 17'd27315;

    // register word index, decoded from paddr[2]
    localparam logic REG_DEVICE_ADDRESS = 1'b0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ PEC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/smbus_pec_read_word_checker.sv @@
// SMBus read-word checker: PEC (CRC-8) check and temperature conversion, one word per cycle unless m_tready stalls.
// Throughput one word per cycle while m_tready does not stall the output.
// Three register stages: CRC of address and command, CRC of read address and low byte
// plus scaling, then CRC of high byte, compare and status. Depends on smbpec_pkg.
// Synchronous active-low reset clears the valid bits and sets device_address to 90.
`timescale 1ns / 1ps
`default_nettype none

`include "smbus_pec_read_word_checker_macros.svh"

module smbus_pec_read_word_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // config port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [smbpec_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [smbpec_pkg::PDATA_W-1:0]     pwdata,
    output logic      [smbpec_pkg::PDATA_W-1:0]     prdata,
    output logic                                    pready,
    // input words
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // command[7:0], data_low[15:8], data_high[23:16], pec_byte[31:24]
    input  wire logic [smbpec_pkg::S_TDATA_W-1:0]   s_tdata,
    // result words
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // raw_word[15:0], temperature_centi[32:16], zero[39:33]
    output logic      [smbpec_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0], temperature_valid[2]
    output logic      [smbpec_pkg::M_TUSER_W-1:0]   m_tuser
);
    import smbpec_pkg::*;

    logic [ADDR_W-1:0] dev_addr_reg;
    logic [ADDR_W-1:0] dev_addr_next;
    logic              cfg_wr;

    logic adv1, adv2, adv3;

    // stage 1
    logic              v1_reg;
    logic [BYTE_W-1:0] crc1_reg, rd1_reg, lo1_reg, hi1_reg, pec1_reg;
    logic [BYTE_W-1:0] crc1_next, wr_byte, rd_byte;

    // stage 2
    logic              v2_reg;
    logic [BYTE_W-1:0] crc2_reg, hi2_reg, pec2_reg, lo2_reg;
    logic [TEMP_W-1:0] temp2_reg;
    logic [BYTE_W-1:0] crc2_next;
    logic [TEMP_W-1:0] temp2_next;

    // stage 3 / output
    logic              v3_reg;
    logic [WORD_W-1:0] raw3_reg;
    status_t           st3_reg;
    logic [TEMP_W-1:0] temp3_reg;
    logic              tv3_reg;
    logic [BYTE_W-1:0] crc3;
    status_t           st3_next;
    logic [TEMP_W-1:0] temp3_next;

    // ---------------- config ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DEVICE_ADDRESS);

    always_comb begin
        dev_addr_next = dev_addr_reg;
        if (cfg_wr) begin
            dev_addr_next = pwdata[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= ADDR_RESET;
        end else begin
            dev_addr_reg <= dev_addr_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_DEVICE_ADDRESS) begin
            prdata = {{(PDATA_W-ADDR_W){1'b0}}, dev_addr_reg};
        end
    end

    // ---------------- flow control ----------------
    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // ---------------- stage 1 ----------------
    assign wr_byte   = {dev_addr_reg, 1'b0};
    assign rd_byte   = {dev_addr_reg, 1'b1};
    assign crc1_next = crc8_byte(crc8_byte(PEC_INIT, wr_byte), s_tdata[7:0]);

    always_ff @(posedge aclk) begin
        if (adv1) begin
            crc1_reg <= crc1_next;
            rd1_reg  <= rd_byte;
            lo1_reg  <= s_tdata[15:8];
            hi1_reg  <= s_tdata[23:16];
            pec1_reg <= s_tdata[31:24];
        end
    end

    // ---------------- stage 2 ----------------
    assign crc2_next  = crc8_byte(crc8_byte(crc1_reg, rd1_reg), lo1_reg);
    // raw*2 - 27315 on the 15 low bits; only used when bit 15 is clear
    assign temp2_next = {1'b0, hi1_reg[6:0], lo1_reg, 1'b0} - ZERO_C_CENTI;

    always_ff @(posedge aclk) begin
        if (adv2) begin
            crc2_reg  <= crc2_next;
            hi2_reg   <= hi1_reg;
            lo2_reg   <= lo1_reg;
            pec2_reg  <= pec1_reg;
            temp2_reg <= temp2_next;
        end
    end

    // ---------------- stage 3 ----------------
    assign crc3 = crc8_byte(crc2_reg, hi2_reg);

    always_comb begin
        priority if (crc3 != pec2_reg) begin
            st3_next = ST_CRC_ERR;
        end else if (hi2_reg[BYTE_W-1]) begin
            st3_next = ST_INVALID;
        end else begin
            st3_next = ST_OK;
        end
        temp3_next = (st3_next == ST_OK) ? temp2_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            raw3_reg  <= {hi2_reg, lo2_reg};
            st3_reg   <= st3_next;
            temp3_reg <= temp3_next;
            tv3_reg   <= (st3_next == ST_OK);
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(M_TDATA_W-TEMP_W-WORD_W){1'b0}}, temp3_reg, raw3_reg};
    assign m_tuser  = {tv3_reg, st3_reg};

    // ---------------- assertions ----------------
    `SPC_ASSERT_NXT(a_s1_to_s2, aclk, aresetn, v1_reg && adv2, v2_reg)
    `SPC_ASSERT_NXT(a_s2_to_s3, aclk, aresetn, v2_reg && adv3, v3_reg)
    `SPC_ASSERT_IMP(a_tv_ok, aclk, aresetn, v3_reg, tv3_reg == (st3_reg == ST_OK))
    `SPC_ASSERT_IMP(a_temp_zero, aclk, aresetn, v3_reg && !tv3_reg, temp3_reg == '0)

endmodule

`default_nettype wire

@@ test/smbus_pec_read_word_checker_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for smbus_pec_read_word_checker: PEC check, status and temperature.
// Drives request words and APB writes, predicts each response word in-bench.
// Depends on smbpec_pkg and the checker RTL.

module smbus_pec_read_word_checker_test;
    import smbpec_pkg::*;

    localparam int unsigned RUN_LIMIT      = 200000;
    localparam int unsigned LONG_HOLD_LEN  = 200;
    localparam int unsigned SETTLE_CYCLES  = 6;

    typedef struct {
        logic [WORD_W-1:0]        raw_word;
        status_t                  status;
        logic signed [TEMP_W-1:0] temperature_centi;
        logic                     temperature_valid;
    } reading_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;     // command, data_low, data_high, pec_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // raw_word, temperature_centi, zero pad
    logic [M_TUSER_W-1:0]   m_tuser;          // status, temperature_valid

    logic [S_TDATA_W-1:0]   pending_words[$];
    reading_t               expected_readings[$];
    logic [ADDR_W-1:0]      bus_addr_model = ADDR_RESET;
    int unsigned            mismatch_count = 0;
    int unsigned            cycle_count = 0;
    int unsigned            sent_count = 0;
    int unsigned            done_count = 0;
    int unsigned            send_gap = 0;
    int unsigned            recv_gap = 0;
    int unsigned            long_hold_left = 0;
    bit                     send_quiet = 1'b0;
    bit                     recv_quiet = 1'b0;
    bit                     long_hold_go = 1'b0;
    bit                     long_hold_done = 1'b0;

    smbus_pec_read_word_checker u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic logic [BYTE_W-1:0] pec_fold(input logic [BYTE_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = acc ^ b;
        repeat (BYTE_W) r = r[BYTE_W-1] ? ((r << 1) ^ PEC_POLY) : (r << 1);
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] packet_pec(input logic [ADDR_W-1:0] dev,
                                                     input logic [BYTE_W-1:0] cmd,
                                                     input logic [BYTE_W-1:0] lo,
                                                     input logic [BYTE_W-1:0] hi);
        logic [BYTE_W-1:0] acc;
        acc = PEC_INIT;
        acc = pec_fold(acc, {dev, 1'b0});
        acc = pec_fold(acc, cmd);
        acc = pec_fold(acc, {dev, 1'b1});
        acc = pec_fold(acc, lo);
        acc = pec_fold(acc, hi);
        return acc;
    endfunction

    function automatic reading_t predict_reading(input logic [S_TDATA_W-1:0] word);
        reading_t r;
        int       centi;
        r.raw_word          = word[23:8];
        r.temperature_centi = '0;
        r.temperature_valid = 1'b0;
        if (packet_pec(bus_addr_model, word[7:0], word[15:8], word[23:16]) != word[31:24]) begin
            r.status = ST_CRC_ERR;
        end else if (r.raw_word[WORD_W-1]) begin
            r.status = ST_INVALID;
        end else begin
            r.status            = ST_OK;
            centi               = int'(r.raw_word) * 2 - int'(ZERO_C_CENTI);
            r.temperature_centi = centi[TEMP_W-1:0];
            r.temperature_valid = 1'b1;
        end
        return r;
    endfunction

    // good_pec=0 corrupts the PEC with a nonzero XOR so it is always wrong
    task automatic queue_reading(input logic [7:0] cmd, input logic [7:0] lo,
                                 input logic [7:0] hi, input bit good_pec);
        logic [7:0] pec;
        pec = packet_pec(bus_addr_model, cmd, lo, hi);
        if (!good_pec) pec = pec ^ 8'($urandom_range(1, 255));
        pending_words.push_back({pec, hi, lo, cmd});
    endtask

    task automatic queue_random(input int unsigned count);
        repeat (count) begin
            queue_reading(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 9) < 8);
        end
    endtask

    task automatic wait_drain();
        while (pending_words.size() != 0 || sent_count != done_count) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_DEVICE_ADDRESS) bus_addr_model = data[ADDR_W-1:0];
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_words.pop_front();
                sent_count++;
                send_gap = send_quiet ? 0 : $urandom_range(0, 13);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // response sink
    always @(posedge aclk) begin
        if (long_hold_go && !long_hold_done) begin
            long_hold_left = LONG_HOLD_LEN;
            long_hold_done = 1'b1;
        end
        if (aresetn && m_tvalid && m_tready) recv_gap = recv_quiet ? 0 : $urandom_range(0, 13);
        if (long_hold_left > 0) begin
            long_hold_left--;
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) expected_readings.push_back(predict_reading(s_tdata));
    end

    always @(posedge aclk) begin
        reading_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                $error("result word with no request pending: tdata %h tuser %h", m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                exp_r = expected_readings.pop_front();
                done_count++;
                if (m_tdata[15:0] !== exp_r.raw_word) begin
                    $error("raw_word: expected %h, got %h", exp_r.raw_word, m_tdata[15:0]);
                    mismatch_count++;
                end
                if (m_tuser[1:0] !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tuser[1:0]);
                    mismatch_count++;
                end
                if (m_tdata[32:16] !== exp_r.temperature_centi) begin
                    $error("temperature_centi: expected %0d, got %0d",
                           exp_r.temperature_centi, $signed(m_tdata[32:16]));
                    mismatch_count++;
                end
                if (m_tuser[2] !== exp_r.temperature_valid) begin
                    $error("temperature_valid: expected %0b, got %0b",
                           exp_r.temperature_valid, m_tuser[2]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [ADDR_W-1:0] phase_addr[4];
        phase_addr[0] = '0;
        phase_addr[1] = '1;
        phase_addr[2] = ADDR_W'($urandom);
        phase_addr[3] = ADDR_W'($urandom);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset address in effect before any write
        queue_reading(8'h07, 8'h3A, 8'h3B, 1'b1);
        queue_reading(8'h06, 8'hFF, 8'h7F, 1'b1);
        wait_drain();

        apb_write({~REG_DEVICE_ADDRESS, 2'b00}, 32'h0000_0011);   // undecoded, must be ignored
        apb_write({REG_DEVICE_ADDRESS, 2'b00}, 32'hABCD_EFDA);    // upper bits dropped -> 90

        queue_reading(8'h00, 8'h00, 8'h00, 1'b1);    // coldest reading
        queue_reading(8'hFF, 8'hFF, 8'h7F, 1'b1);    // hottest valid reading
        queue_reading(8'h07, 8'h00, 8'h80, 1'b1);    // invalid flag only
        queue_reading(8'h07, 8'hFF, 8'hFF, 1'b1);
        queue_reading(8'h07, 8'hFF, 8'hFF, 1'b0);    // bad PEC wins over invalid flag
        queue_reading(8'h07, 8'h00, 8'h80, 1'b0);
        queue_reading(8'h07, 8'hB0, 8'h3A, 1'b0);    // bad PEC, valid range
        queue_reading(8'h07, 8'h5A, 8'h35, 1'b1);    // just above 0 C
        queue_reading(8'h07, 8'h59, 8'h35, 1'b1);    // just below 0 C
        queue_reading(8'h08, 8'h5C, 8'h35, 1'b1);
        queue_reading(8'h00, 8'hAA, 8'h55, 1'b1);
        queue_reading(8'hFF, 8'h55, 8'h2A, 1'b0);
        pending_words.push_back({8'h00, 8'h12, 8'h34, 8'h07});
        pending_words.push_back({8'hFF, 8'h12, 8'h34, 8'h07});
        pending_words.push_back({8'h00, 8'hFF, 8'hFF, 8'hFF});
        pending_words.push_back({8'hFF, 8'h00, 8'h00, 8'h00});
        wait_drain();

        // back-to-back on both sides
        send_quiet = 1'b1;
        recv_quiet = 1'b1;
        apb_write({REG_DEVICE_ADDRESS, 2'b00}, PDATA_W'(phase_addr[0]));
        queue_random(100);
        wait_drain();

        // sink holds off long enough to back the pipe up into the input
        recv_quiet = 1'b0;
        apb_write({REG_DEVICE_ADDRESS, 2'b00}, PDATA_W'(phase_addr[1]));
        long_hold_go = 1'b1;
        queue_random(40);
        wait_drain();
        send_quiet = 1'b0;
        queue_random(30);
        wait_drain();
        queue_random(30);
        wait_drain();

        for (int p = 2; p < 4; p++) begin
            apb_write({REG_DEVICE_ADDRESS, 2'b00}, {$urandom} << ADDR_W | PDATA_W'(phase_addr[p]));
            queue_random(200);
            wait_drain();
        end

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
